### sv/spa_pkg.sv
// Shared types and constants for the sparse polynomial adder.
// No dependencies; imported by every module of the block.
package spa_pkg;

    localparam int TERMS_PER_POLY  = 32;
    localparam int EXP_BITS        = 10;
    localparam int COEFF_FRAC_BITS = 16;
    localparam int COEFF_W         = 32;
    localparam int IDX_W           = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;
    localparam int CNT_W           = $clog2(TERMS_PER_POLY + 1);

    // Input word codes
    localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
    localparam logic [1:0] MODE_START       = 2'd2;

    // One stored term (coefficient is Q16.16)
    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff;
        logic [EXP_BITS-1:0]       exponent;
    } spa_term_t;

    // One sum word handed from the merge walk to the output register
    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff;
        logic [EXP_BITS-1:0]       exponent;
        logic                      last_term;
        logic                      empty_sum;
        logic                      saturated;
        logic                      terms_dropped;
    } spa_item_t;

endpackage

### sv/spa_term_ram.sv
// Term store: one write port, one read port with registered read data.
// Depends on spa_pkg for the term type and depth.
module spa_term_ram
    import spa_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  spa_term_t        wdata,
    input  logic [IDX_W-1:0] raddr,
    output spa_term_t        rdata
);

    spa_term_t mem [TERMS_PER_POLY];
    spa_term_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/spa_merge.sv
// Merge walk over both term stores: compares head exponents, adds with
// saturation, and holds one word back so the final one can carry last_term.
// Depends on spa_pkg.
module spa_merge
    import spa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             drop_in,
    input  logic [CNT_W-1:0] first_count,
    input  logic [CNT_W-1:0] second_count,
    input  spa_term_t        first_rd,
    input  spa_term_t        second_rd,
    input  logic             out_free,
    output logic             busy,
    output logic [IDX_W-1:0] first_addr,
    output logic [IDX_W-1:0] second_addr,
    output logic             item_valid,
    output spa_item_t        item,
    output logic             done
);

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] a_reg, a_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic             drop_reg, drop_next;
    logic             pend_valid_reg, pend_valid_next;
    spa_item_t        pend_reg, pend_next;

    logic                      ha, hb, eq, take_a;
    logic signed [COEFF_W:0]   sum_wide;
    logic                      sum_ovf;
    logic signed [COEFF_W-1:0] sum_sat;
    logic                      produce;
    spa_item_t                 cand;

    // Head compare and saturating add
    always_comb
    begin
        ha       = a_reg < first_count;
        hb       = b_reg < second_count;
        eq       = ha && hb && (first_rd.exponent == second_rd.exponent);
        take_a   = ha && (!hb || (first_rd.exponent > second_rd.exponent));
        sum_wide = {first_rd.coeff[COEFF_W-1], first_rd.coeff}
                 + {second_rd.coeff[COEFF_W-1], second_rd.coeff};
        sum_ovf  = sum_wide[COEFF_W] != sum_wide[COEFF_W-1];
        if (sum_ovf)
        begin
            sum_sat = sum_wide[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}}
                                        : {1'b0, {(COEFF_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[COEFF_W-1:0];
        end

        cand.last_term     = 1'b0;
        cand.empty_sum     = 1'b0;
        cand.terms_dropped = drop_reg;
        if (eq)
        begin
            cand.coeff     = sum_sat;
            cand.exponent  = first_rd.exponent;
            cand.saturated = sum_ovf;
        end
        else if (take_a)
        begin
            cand.coeff     = first_rd.coeff;
            cand.exponent  = first_rd.exponent;
            cand.saturated = 1'b0;
        end
        else
        begin
            cand.coeff     = second_rd.coeff;
            cand.exponent  = second_rd.exponent;
            cand.saturated = 1'b0;
        end
        produce = eq ? (sum_sat != '0) : (ha || hb);
    end

    // Walk control
    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        drop_next       = drop_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        item_valid      = 1'b0;
        item            = pend_reg;
        done            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                a_next = '0;
                b_next = '0;
                if (start)
                begin
                    drop_next       = drop_in;
                    pend_valid_next = 1'b0;
                    state_next      = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (!ha && !hb)
                begin
                    // Finish: flush held word as last, or send the empty marker
                    if (out_free)
                    begin
                        item_valid = 1'b1;
                        if (pend_valid_reg)
                        begin
                            item.last_term = 1'b1;
                        end
                        else
                        begin
                            item.coeff         = '0;
                            item.exponent      = '0;
                            item.last_term     = 1'b1;
                            item.empty_sum     = 1'b1;
                            item.saturated     = 1'b0;
                            item.terms_dropped = drop_reg;
                        end
                        pend_valid_next = 1'b0;
                        done            = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (!produce || !pend_valid_reg || out_free)
                begin
                    // Advance heads; push out the held word when a new one arrives
                    a_next = a_reg + CNT_W'(eq || take_a);
                    b_next = b_reg + CNT_W'(eq || !take_a);
                    if (produce)
                    begin
                        item_valid      = pend_valid_reg;
                        pend_next       = cand;
                        pend_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            a_reg          <= '0;
            b_reg          <= '0;
            drop_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            drop_reg       <= drop_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
        end
    end

    assign busy        = state_reg != ST_IDLE;
    assign first_addr  = a_next[IDX_W-1:0];
    assign second_addr = b_next[IDX_W-1:0];

endmodule

### sv/sparse_polynomial_adder.sv
// Sparse polynomial adder; depends on spa_pkg, spa_term_ram and spa_merge.
// Loads stream back to back. A start word runs a merge that reads each term store
// through its single read port; input is stalled during the merge. Reset clears
// both fill counts and the overflow flag; store contents are left as they are,
// only entries below the counts are read.
module sparse_polynomial_adder
    import spa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      term_valid,
    output logic                      term_stall,
    input  logic [1:0]                mode,
    input  logic signed [COEFF_W-1:0] coeff_in,
    input  logic [EXP_BITS-1:0]       exponent_in,
    output logic                      sum_valid,
    input  logic                      sum_stall,
    output logic signed [COEFF_W-1:0] coeff_out,
    output logic [EXP_BITS-1:0]       exponent_out,
    output logic                      last_term,
    output logic                      empty_sum,
    output logic                      saturated,
    output logic                      terms_dropped
);

    logic [CNT_W-1:0] first_count_reg, first_count_next;
    logic [CNT_W-1:0] second_count_reg, second_count_next;
    logic             overflow_reg, overflow_next;
    logic             out_valid_reg;
    spa_item_t        out_reg;

    logic             accept, start, busy, done, out_free, item_valid;
    logic             first_we, second_we;
    logic             first_full, second_full;
    logic [IDX_W-1:0] first_addr, second_addr;
    spa_term_t        wterm, first_rd, second_rd;
    spa_item_t        item;

    assign accept      = term_valid && !term_stall;
    assign term_stall  = busy;
    assign start       = accept && (mode == MODE_START);
    assign first_full  = first_count_reg == CNT_W'(TERMS_PER_POLY);
    assign second_full = second_count_reg == CNT_W'(TERMS_PER_POLY);
    assign first_we    = accept && (mode == MODE_LOAD_FIRST) && !first_full;
    assign second_we   = accept && (mode == MODE_LOAD_SECOND) && !second_full;
    assign wterm.coeff    = coeff_in;
    assign wterm.exponent = exponent_in;

    // Fill counts and overflow flag
    always_comb
    begin
        first_count_next  = first_count_reg + CNT_W'(first_we);
        second_count_next = second_count_reg + CNT_W'(second_we);
        overflow_next     = overflow_reg;
        if (accept && (((mode == MODE_LOAD_FIRST) && first_full)
                    || ((mode == MODE_LOAD_SECOND) && second_full)))
        begin
            overflow_next = 1'b1;
        end
        if (start)
        begin
            overflow_next = 1'b0;
        end
        if (done)
        begin
            first_count_next  = '0;
            second_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            overflow_reg     <= 1'b0;
        end
        else
        begin
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            overflow_reg     <= overflow_next;
        end
    end

    // Term stores
    spa_term_ram u_first_ram (
        .clk   (clk),
        .we    (first_we),
        .waddr (first_count_reg[IDX_W-1:0]),
        .wdata (wterm),
        .raddr (first_addr),
        .rdata (first_rd)
    );

    spa_term_ram u_second_ram (
        .clk   (clk),
        .we    (second_we),
        .waddr (second_count_reg[IDX_W-1:0]),
        .wdata (wterm),
        .raddr (second_addr),
        .rdata (second_rd)
    );

    // Merge walk
    spa_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .drop_in      (overflow_reg),
        .first_count  (first_count_reg),
        .second_count (second_count_reg),
        .first_rd     (first_rd),
        .second_rd    (second_rd),
        .out_free     (out_free),
        .busy         (busy),
        .first_addr   (first_addr),
        .second_addr  (second_addr),
        .item_valid   (item_valid),
        .item         (item),
        .done         (done)
    );

    // Output register: load a new word when empty or being taken
    assign out_free = !out_valid_reg || !sum_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && item_valid)
        begin
            out_reg <= item;
        end
    end

    assign sum_valid     = out_valid_reg;
    assign coeff_out     = out_reg.coeff;
    assign exponent_out  = out_reg.exponent;
    assign last_term     = out_reg.last_term;
    assign empty_sum     = out_reg.empty_sum;
    assign saturated     = out_reg.saturated;
    assign terms_dropped = out_reg.terms_dropped;

endmodule

### dv/tb.sv
// Self-checking testbench for sparse_polynomial_adder: loads term words into both
// stores, starts additions and checks every sum word against a merge predictor.
// Depends on spa_pkg and the sparse_polynomial_adder RTL.
module tb;
    import spa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Mode code the block must ignore
    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int WORD_TARGET   = 410;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 64;

    // Tracks both term stores and predicts the sum words of each start
    class poly_sum_tracker;
        spa_term_t first_store[TERMS_PER_POLY];
        spa_term_t second_store[TERMS_PER_POLY];
        int        first_fill;
        int        second_fill;
        bit        overflow_seen;
        spa_item_t expected_sums[$];
        int        errors;
        int        additions;
        int        sums_checked;
        int        saturated_sums;
        int        empty_sums;
        int        dropped_flags;

        function new();
            first_fill    = 0;
            second_fill   = 0;
            overflow_seen = 1'b0;
            errors        = 0;
            additions     = 0;
            sums_checked  = 0;
            saturated_sums = 0;
            empty_sums    = 0;
            dropped_flags = 0;
        endfunction

        function spa_item_t make_sum(logic signed [COEFF_W-1:0] c, logic [EXP_BITS-1:0] e,
                                     bit sat, bit emp);
            spa_item_t s;
            s.coeff         = c;
            s.exponent      = e;
            s.last_term     = 1'b0;
            s.empty_sum     = emp;
            s.saturated     = sat;
            s.terms_dropped = overflow_seen;
            return s;
        endfunction

        // Apply one accepted input word; a start queues its sum words
        function void note_word(logic [1:0] m, logic signed [COEFF_W-1:0] c,
                                logic [EXP_BITS-1:0] e);
            int        a;
            int        b;
            longint    total;
            bit        sat;
            spa_item_t sums[$];
            spa_term_t ta;
            spa_term_t tb_term;
            a = 0;
            b = 0;
            if (m == MODE_LOAD_FIRST || m == MODE_LOAD_SECOND)
            begin
                if (m == MODE_LOAD_FIRST && first_fill < TERMS_PER_POLY)
                begin
                    first_store[IDX_W'(first_fill)] = '{coeff: c, exponent: e};
                    first_fill++;
                end
                else if (m == MODE_LOAD_SECOND && second_fill < TERMS_PER_POLY)
                begin
                    second_store[IDX_W'(second_fill)] = '{coeff: c, exponent: e};
                    second_fill++;
                end
                else
                    overflow_seen = 1'b1;
                return;
            end
            if (m != MODE_START)
                return;

            // Walk both stores by head exponent, larger head first
            additions++;
            while (a < first_fill || b < second_fill)
            begin
                ta      = first_store[IDX_W'(a)];
                tb_term = second_store[IDX_W'(b)];
                if (a < first_fill && b < second_fill && ta.exponent == tb_term.exponent)
                begin
                    total = longint'(ta.coeff) + longint'(tb_term.coeff);
                    sat   = 1'b0;
                    if (total > 64'sd2147483647)
                    begin
                        total = 64'sd2147483647;
                        sat   = 1'b1;
                    end
                    if (total < -64'sd2147483648)
                    begin
                        total = -64'sd2147483648;
                        sat   = 1'b1;
                    end
                    // drop a cancelled term
                    if (total != 0)
                        sums.push_back(make_sum(COEFF_W'(total), ta.exponent, sat, 1'b0));
                    a++;
                    b++;
                end
                else if (a < first_fill && (b >= second_fill || ta.exponent > tb_term.exponent))
                begin
                    sums.push_back(make_sum(ta.coeff, ta.exponent, 1'b0, 1'b0));
                    a++;
                end
                else
                begin
                    sums.push_back(make_sum(tb_term.coeff, tb_term.exponent, 1'b0, 1'b0));
                    b++;
                end
            end
            if (sums.size() == 0)
                sums.push_back(make_sum('0, '0, 1'b0, 1'b1));
            sums[sums.size()-1].last_term = 1'b1;
            foreach (sums[i])
                expected_sums.push_back(sums[i]);
            first_fill    = 0;
            second_fill   = 0;
            overflow_seen = 1'b0;
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted sum word with the oldest expectation
        function void check_sum(spa_item_t got);
            spa_item_t want;
            if (expected_sums.size() == 0)
            begin
                $error("sum word with nothing expected: coeff %0d exponent %0d",
                       got.coeff, got.exponent);
                errors++;
                return;
            end
            want = expected_sums.pop_front();
            sums_checked++;
            saturated_sums += int'(want.saturated);
            empty_sums     += int'(want.empty_sum);
            dropped_flags  += int'(want.terms_dropped);
            compare_field("coeff_out", longint'(want.coeff), longint'(got.coeff));
            compare_field("exponent_out", longint'(want.exponent), longint'(got.exponent));
            compare_field("last_term", longint'(want.last_term), longint'(got.last_term));
            compare_field("empty_sum", longint'(want.empty_sum), longint'(got.empty_sum));
            compare_field("saturated", longint'(want.saturated), longint'(got.saturated));
            compare_field("terms_dropped", longint'(want.terms_dropped),
                          longint'(got.terms_dropped));
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      term_valid;
    logic                      term_stall;
    logic [1:0]                mode;
    logic signed [COEFF_W-1:0] coeff_in;
    logic [EXP_BITS-1:0]       exponent_in;
    logic                      sum_valid;
    logic                      sum_stall;
    logic signed [COEFF_W-1:0] coeff_out;
    logic [EXP_BITS-1:0]       exponent_out;
    logic                      last_term;
    logic                      empty_sum;
    logic                      saturated;
    logic                      terms_dropped;

    poly_sum_tracker sb = new();
    int  words_sent  = 0;
    int  burst_left  = 0;
    bit  quiet_sender = 1'b0;
    bit  hold_req    = 1'b0;

    sparse_polynomial_adder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .term_valid    (term_valid),
        .term_stall    (term_stall),
        .mode          (mode),
        .coeff_in      (coeff_in),
        .exponent_in   (exponent_in),
        .sum_valid     (sum_valid),
        .sum_stall     (sum_stall),
        .coeff_out     (coeff_out),
        .exponent_out  (exponent_out),
        .last_term     (last_term),
        .empty_sum     (empty_sum),
        .saturated     (saturated),
        .terms_dropped (terms_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick a coefficient: extremes, zero, small Q16.16 values or full random
    function automatic logic signed [COEFF_W-1:0] pick_coeff();
        int v;
        v = int'($urandom_range(0, 4000)) - 2000;
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3, 4, 5: return (v <<< COEFF_FRAC_BITS) | int'($urandom_range(0, 65535));
            default: return $urandom;
        endcase
    endfunction

    // Offer one word, hold it until accepted, then idle between bursts unless quiet_sender is set
    task automatic send_word(logic [1:0] m, logic signed [COEFF_W-1:0] c,
                             logic [EXP_BITS-1:0] e);
        int gap;
        term_valid  <= 1'b1;
        mode        <= m;
        coeff_in    <= c;
        exponent_in <= e;
        do
            @(posedge clk);
        while (term_stall);
        sb.note_word(m, c, e);
        if (m != MODE_IGNORED)
            words_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            gap = quiet_sender ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                term_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Pause the sender until every queued sum word has come out
    task automatic wait_for_sums();
        term_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Load two polynomials, interleaved across the stores, then start
    task automatic run_addition(int slots, bit ordered, bit noisy, int overfill);
        spa_term_t first_q[$];
        spa_term_t second_q[$];
        spa_term_t t;
        int        e;
        int        max_step;
        int        pick;
        logic signed [COEFF_W-1:0] c;
        e = $urandom_range(slots, 1023);
        max_step = (slots > 0) ? e / slots : 1;
        for (int i = 0; i < slots; i++)
        begin
            if (!ordered)
                e = $urandom_range(0, 1023);
            c    = pick_coeff();
            pick = $urandom_range(0, 2);
            if (pick != 1)
                first_q.push_back('{coeff: c, exponent: EXP_BITS'(e)});
            if (pick == 2)
            begin
                t.coeff    = ($urandom_range(0, 2) == 0) ? -c : pick_coeff();
                t.exponent = EXP_BITS'(e);
                second_q.push_back(t);
            end
            else if (pick == 1)
                second_q.push_back('{coeff: c, exponent: EXP_BITS'(e)});
            if (ordered)
                e -= $urandom_range(1, max_step);
        end
        // push one store past its capacity
        while (overfill == 1 && first_q.size() < TERMS_PER_POLY + 2)
            first_q.push_back('{coeff: pick_coeff(), exponent: EXP_BITS'($urandom)});
        while (overfill == 2 && second_q.size() < TERMS_PER_POLY + 3)
            second_q.push_back('{coeff: pick_coeff(), exponent: EXP_BITS'($urandom)});

        while (first_q.size() + second_q.size() > 0)
        begin
            if (noisy && $urandom_range(0, 5) == 0)
                send_word(MODE_IGNORED, $urandom, EXP_BITS'($urandom));
            if (second_q.size() == 0 || (first_q.size() != 0 && $urandom_range(0, 1)))
            begin
                t = first_q.pop_front();
                send_word(MODE_LOAD_FIRST, t.coeff, t.exponent);
            end
            else
            begin
                t = second_q.pop_front();
                send_word(MODE_LOAD_SECOND, t.coeff, t.exponent);
            end
        end
        send_word(MODE_START, $urandom, EXP_BITS'($urandom));
    endtask

    // Stimulus
    initial
    begin
        int r;
        int slots;
        int round;
        rst_n       <= 1'b0;
        term_valid  <= 1'b0;
        mode        <= MODE_LOAD_FIRST;
        coeff_in    <= '0;
        exponent_in <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Start with both stores empty
        send_word(MODE_START, 32'sh1234_5678, 10'd1023);

        // Saturate both ways, cancel a pair, pass a zero term, ignore mode three
        send_word(MODE_LOAD_FIRST, 32'sh7FFF_FFFF, 10'd1023);
        send_word(MODE_LOAD_SECOND, 32'sh7FFF_FFFF, 10'd1023);
        send_word(MODE_LOAD_SECOND, 32'sh0001_0000, 10'd700);
        send_word(MODE_LOAD_FIRST, 32'sh0000_0000, 10'd512);
        send_word(MODE_IGNORED, 32'shFFFF_FFFF, 10'd3);
        send_word(MODE_LOAD_FIRST, 32'sh0005_0000, 10'd300);
        send_word(MODE_LOAD_SECOND, -32'sh0005_0000, 10'd300);
        send_word(MODE_LOAD_FIRST, 32'sh8000_0000, 10'd0);
        send_word(MODE_LOAD_SECOND, 32'sh8000_0000, 10'd0);
        send_word(MODE_START, '0, '0);

        // Every term cancels
        send_word(MODE_LOAD_FIRST, 32'sh0000_0003, 10'd9);
        send_word(MODE_LOAD_SECOND, -32'sh0000_0003, 10'd9);
        send_word(MODE_START, '0, '0);

        // Exponents out of order
        send_word(MODE_LOAD_FIRST, 32'sh0002_8000, 10'd5);
        send_word(MODE_LOAD_FIRST, -32'sh0001_0000, 10'd900);
        send_word(MODE_LOAD_SECOND, 32'sh0003_0000, 10'd900);
        send_word(MODE_LOAD_FIRST, 32'sh0004_0000, 10'd900);
        send_word(MODE_LOAD_SECOND, 32'sh0000_0001, 10'd10);
        send_word(MODE_START, '0, '0);

        // Overfill each store once
        run_addition(6, 1'b1, 1'b0, 1);
        run_addition(4, 1'b1, 1'b0, 2);
        wait_for_sums();

        // Random additions, mostly well ordered and small
        round = 0;
        while (words_sent < WORD_TARGET)
        begin
            round++;
            quiet_sender = ($urandom_range(0, 3) == 0);
            if (round == 4)
            begin
                // hold off the receiver while a large addition and more loads arrive
                hold_req = 1'b1;
                run_addition(30, 1'b1, 1'b0, 0);
                run_addition(8, 1'b1, 1'b0, 0);
            end
            r = $urandom_range(0, 9);
            slots = (r < 7) ? $urandom_range(0, 6)
                  : (r < 9) ? $urandom_range(7, 20) : $urandom_range(21, 40);
            run_addition(slots, $urandom_range(0, 9) < 8, $urandom_range(0, 4) == 0,
                         ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0);
            if (round == 8 || $urandom_range(0, 7) == 0)
                wait_for_sums();
        end

        wait_for_sums();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d words in %0d additions; checked %0d sum words", words_sent,
                 sb.additions, sb.sums_checked);
        $display("  of which %0d saturated, %0d empty, %0d flagged with dropped terms",
                 sb.saturated_sums, sb.empty_sums, sb.dropped_flags);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Receiver stall pattern, with one long hold-off on request
    initial
    begin
        int hold_left;
        int phase_left;
        int style;
        hold_left  = 0;
        phase_left = 0;
        style      = 0;
        sum_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                sum_stall <= 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    style      = $urandom_range(0, 3);
                    phase_left = $urandom_range(10, 80);
                end
                phase_left--;
                case (style)
                    0: sum_stall <= 1'b0;
                    1: sum_stall <= ($urandom_range(0, 3) == 0);
                    2: sum_stall <= ($urandom_range(0, 3) != 0);
                    default: sum_stall <= ~sum_stall;
                endcase
            end
        end
    end

    // Check each accepted sum word
    initial
    begin
        spa_item_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && sum_valid && !sum_stall)
            begin
                got.coeff         = coeff_out;
                got.exponent      = exponent_out;
                got.last_term     = last_term;
                got.empty_sum     = empty_sum;
                got.saturated     = saturated;
                got.terms_dropped = terms_dropped;
                sb.check_sum(got);
            end
        end
    end

    // Give up well past the slowest correct run
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
sv/spa_pkg.sv
sv/spa_term_ram.sv
sv/spa_merge.sv
sv/sparse_polynomial_adder.sv
dv/tb.sv
